>>> rtl/bldcsc_pkg.sv
// shared types and constants of the sensorless bldc commutation block
`default_nettype none

package bldcsc_pkg;

  localparam int FIELD_W   = 24;
  localparam int LIMIT_W   = 25;
  localparam int ANGLE_W   = 6;
  localparam int OFFSET_W  = 4;
  localparam int MASK_W    = 6;
  localparam int INDEX_W   = 5;
  localparam int STEP_W    = 3;
  localparam int COUNT_W   = 32;
  localparam int CFG_IDX_W = 4;

  localparam int PHASE_STEPS = 6;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PHASE_STEPS - 1);

  localparam logic [FIELD_W-1:0]  PERIOD_MAX_RST  = FIELD_W'(60 * 1000);
  localparam logic [ANGLE_W-1:0]  PHASE_ANGLE_RST = ANGLE_W'(24);
  localparam logic [OFFSET_W-1:0] PHASE_OFFS_RST  = '0;
  localparam logic [MASK_W-1:0]   RISING_MASK_RST = MASK_W'(21);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_MAX  = 4'd0,
    CFG_PHASE_ANGLE = 4'd1,
    CFG_PHASE_OFFS  = 4'd2,
    CFG_RISING_MASK = 4'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  period_max;
    logic [ANGLE_W-1:0]  phase_angle;
    logic [OFFSET_W-1:0] phase_offset;
    logic [MASK_W-1:0]   rising_mask;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic               comparator;
    logic [FIELD_W-1:0] first_period;
    logic [FIELD_W-1:0] delay_min;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] drive_index;
    logic [INDEX_W-1:0] next_index;
    logic               commutated;
    logic               detect_done;
    logic               crossing_seen;
    logic [COUNT_W-1:0] step_total;
    logic [FIELD_W-1:0] period_out;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/bldcsc_in_if.sv
// input item channel: tick or start command
`default_nettype none

interface bldcsc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic                           comparator;
  logic [bldcsc_pkg::FIELD_W-1:0] first_period;
  logic [bldcsc_pkg::FIELD_W-1:0] delay_min;

  modport source (output valid, kind, comparator, first_period, delay_min, input ready);
  modport sink (input valid, kind, comparator, first_period, delay_min, output ready);
endinterface

`default_nettype wire

>>> rtl/bldcsc_out_if.sv
// result item channel
`default_nettype none

interface bldcsc_out_if;
  logic                           valid;
  logic                           ready;
  logic [bldcsc_pkg::INDEX_W-1:0] drive_index;
  logic [bldcsc_pkg::INDEX_W-1:0] next_index;
  logic                           commutated;
  logic                           detect_done;
  logic                           crossing_seen;
  logic [bldcsc_pkg::COUNT_W-1:0] step_total;
  logic [bldcsc_pkg::FIELD_W-1:0] period_out;

  modport source (output valid, drive_index, next_index, commutated, detect_done,
                  crossing_seen, step_total, period_out, input ready);
  modport sink (input valid, drive_index, next_index, commutated, detect_done,
                crossing_seen, step_total, period_out, output ready);
endinterface

`default_nettype wire

>>> rtl/bldcsc_cfg_if.sv
// configuration write channel
`default_nettype none

interface bldcsc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bldcsc_pkg::CFG_IDX_W-1:0] index;
  logic [bldcsc_pkg::FIELD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/bldcsc_core.sv
// commutation state and its per-item next-state logic
`default_nettype none

module bldcsc_core #(
  parameter int TIMER_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fire,
  input  wire bldcsc_pkg::in_item_t item,
  input  wire bldcsc_pkg::cfg_t     cfg,
  output bldcsc_pkg::out_item_t     result
);

  localparam int PW = (TIMER_BITS < bldcsc_pkg::FIELD_W) ? TIMER_BITS : bldcsc_pkg::FIELD_W;
  localparam int DW = (TIMER_BITS > bldcsc_pkg::FIELD_W) ? TIMER_BITS : bldcsc_pkg::FIELD_W;
  localparam int CW = (TIMER_BITS > bldcsc_pkg::LIMIT_W) ? TIMER_BITS : bldcsc_pkg::LIMIT_W;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  typedef enum logic [1:0] {MODE_IDLE, MODE_BLANK, MODE_DETECT} mode_t;

  logic [TIMER_BITS-1:0]             timestamp_r, timestamp_nxt;
  logic [TIMER_BITS-1:0]             since_r, since_nxt;
  logic [PW-1:0]                     period_r, period_nxt;
  logic [TIMER_BITS-1:0]             last_r, last_nxt;
  logic [TIMER_BITS-1:0]             commutate_at_r, commutate_at_nxt;
  logic [TIMER_BITS-1:0]             detect_at_r, detect_at_nxt;
  logic [bldcsc_pkg::LIMIT_W-1:0]    limit_r, limit_nxt;
  mode_t                             mode_r, mode_nxt;
  logic [bldcsc_pkg::COUNT_W-1:0]    count_r, count_nxt;
  logic [bldcsc_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [bldcsc_pkg::INDEX_W-1:0]    drive_r, drive_nxt;
  logic [bldcsc_pkg::INDEX_W-1:0]    pending_r, pending_nxt;
  logic [bldcsc_pkg::OFFSET_W-1:0]   offset_r, offset_nxt;

  logic [TIMER_BITS-1:0]             ts_inc, sc_inc;
  logic [DW-1:0]                     delay_w, first_w, pmax_w, avg_w;
  logic [TIMER_BITS-1:0]             interval;
  logic [TIMER_BITS:0]               avg_sum;
  logic [PW-1:0]                     per_cl;
  logic [PW+5:0]                     angle_prod;
  logic [PW+1:0]                     three_q;
  logic [TIMER_BITS-1:0]             cat_cl, det_cl;
  logic [bldcsc_pkg::STEP_W-1:0]     step_cl;
  logic [bldcsc_pkg::INDEX_W-1:0]    pend_cl;
  logic [7:0]                        mask_ext;
  logic                              want;
  logic [bldcsc_pkg::LIMIT_W-1:0]    limit_v;
  mode_t                             mode_v;
  logic                              commutated, done, seen;

  // window closing datapath
  assign ts_inc     = timestamp_r + 1'b1;
  assign sc_inc     = since_r + 1'b1;
  assign delay_w    = DW'(item.delay_min);
  assign first_w    = DW'(item.first_period);
  assign pmax_w     = DW'(cfg.period_max);
  assign interval   = ts_inc - last_r;
  assign avg_sum    = (TIMER_BITS + 1)'(period_r) + (TIMER_BITS + 1)'(interval);
  assign avg_w      = DW'(avg_sum[TIMER_BITS:1]);
  assign per_cl     = (avg_w > pmax_w) ? pmax_w[PW-1:0] : avg_w[PW-1:0];
  assign angle_prod = (PW + 6)'(per_cl) * (PW + 6)'(cfg.phase_angle);
  assign three_q    = (PW + 2)'({per_cl, 1'b0}) + (PW + 2)'(per_cl);
  assign cat_cl     = TIMER_BITS'(angle_prod[PW+5:6]);
  assign det_cl     = ts_inc + TIMER_BITS'(three_q[PW+1:2]);
  assign step_cl    = (step_r == bldcsc_pkg::STEP_LAST) ? '0 : step_r + 1'b1;
  assign pend_cl    = bldcsc_pkg::INDEX_W'(step_cl) + bldcsc_pkg::INDEX_W'(offset_r);
  assign mask_ext   = 8'(cfg.rising_mask);
  assign want       = mask_ext[step_r];

  always_comb begin
    timestamp_nxt    = timestamp_r;
    since_nxt        = since_r;
    period_nxt       = period_r;
    last_nxt         = last_r;
    commutate_at_nxt = commutate_at_r;
    detect_at_nxt    = detect_at_r;
    limit_nxt        = limit_r;
    mode_nxt         = mode_r;
    count_nxt        = count_r;
    step_nxt         = step_r;
    drive_nxt        = drive_r;
    pending_nxt      = pending_r;
    offset_nxt       = offset_r;
    commutated       = 1'b0;
    done             = 1'b0;
    seen             = 1'b0;
    limit_v          = limit_r;
    mode_v           = mode_r;
    if (item.kind) begin
      period_nxt       = first_w[PW-1:0];
      since_nxt        = '0;
      commutate_at_nxt = TIMER_BITS'(first_w[PW-1:0]);
      last_nxt         = timestamp_r;
      detect_at_nxt    = timestamp_r + delay_w[TIMER_BITS-1:0];
      count_nxt        = '0;
      drive_nxt        = bldcsc_pkg::INDEX_W'(step_r);
      pending_nxt      = bldcsc_pkg::INDEX_W'(step_r);
      offset_nxt       = cfg.phase_offset;
      mode_nxt         = MODE_BLANK;
    end else begin
      timestamp_nxt = ts_inc;
      since_nxt     = sc_inc;
      if (commutate_at_r != TMAX && sc_inc >= commutate_at_r) begin
        drive_nxt        = pending_r;
        commutate_at_nxt = TMAX;
        commutated       = 1'b1;
      end
      // window opens in the same tick
      if (mode_r == MODE_BLANK && ts_inc == detect_at_r) begin
        since_nxt        = '0;
        commutate_at_nxt = TMAX;
        limit_v          = bldcsc_pkg::LIMIT_W'({period_r, 1'b0});
        limit_nxt        = limit_v;
        mode_v           = MODE_DETECT;
        mode_nxt         = MODE_DETECT;
      end
      if (mode_v == MODE_DETECT) begin
        if (item.comparator == want) begin
          done = 1'b1;
          seen = 1'b1;
        end else if (CW'(since_nxt) >= CW'(limit_v)) begin
          done = 1'b1;
        end
      end
      if (done) begin
        last_nxt         = ts_inc;
        period_nxt       = per_cl;
        count_nxt        = count_r + bldcsc_pkg::COUNT_W'(seen);
        commutate_at_nxt = cat_cl;
        since_nxt        = '0;
        detect_at_nxt    = det_cl;
        step_nxt         = step_cl;
        pending_nxt      = pend_cl;
        mode_nxt         = MODE_BLANK;
      end
    end
  end

  always_comb begin
    result.drive_index   = drive_nxt;
    result.next_index    = pending_nxt;
    result.commutated    = commutated;
    result.detect_done   = done;
    result.crossing_seen = seen;
    result.step_total    = count_nxt;
    result.period_out    = bldcsc_pkg::FIELD_W'(period_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timestamp_r    <= '0;
      since_r        <= '0;
      period_r       <= '0;
      last_r         <= '0;
      commutate_at_r <= TMAX;
      detect_at_r    <= '0;
      limit_r        <= '0;
      mode_r         <= MODE_IDLE;
      count_r        <= '0;
      step_r         <= '0;
      drive_r        <= '0;
      pending_r      <= '0;
      offset_r       <= '0;
    end else if (fire) begin
      timestamp_r    <= timestamp_nxt;
      since_r        <= since_nxt;
      period_r       <= period_nxt;
      last_r         <= last_nxt;
      commutate_at_r <= commutate_at_nxt;
      detect_at_r    <= detect_at_nxt;
      limit_r        <= limit_nxt;
      mode_r         <= mode_nxt;
      count_r        <= count_nxt;
      step_r         <= step_nxt;
      drive_r        <= drive_nxt;
      pending_r      <= pending_nxt;
      offset_r       <= offset_nxt;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= bldcsc_pkg::STEP_LAST)
    else $error("step index out of range");

  a_close_blanks: assert property (@(posedge clk) disable iff (!rst_n)
    fire && done |=> mode_r == MODE_BLANK && since_r == '0)
    else $error("window close did not re-enter blanking");

  a_close_pending: assert property (@(posedge clk) disable iff (!rst_n)
    fire && done |=> pending_r == bldcsc_pkg::INDEX_W'(step_r) + bldcsc_pkg::INDEX_W'(offset_r))
    else $error("pending drive index mismatch after window close");

endmodule

`default_nettype wire

>>> rtl/bldc_sensorless_commutation_top.sv
// top level of the sensorless bldc back-emf commutation block
// Sensorless BLDC commutation: every accepted item is either one timer tick
// with a comparator sample or a start command, and yields exactly one result
// item. One item is accepted per clock unless the result side stalls; a result
// is presented from the result register after its item has passed the input
// register, and stalls on the result side back up into the input channel only
// once both registers are full. The per-item path is set by the period average
// and clamp feeding the 24x6 commutation-delay multiply. Configuration writes
// are taken every cycle and are meant to happen while no item is in flight.
`default_nettype none

module bldc_sensorless_commutation_top #(
  parameter int TIMER_BITS = 24
) (
  input wire logic      clk,
  input wire logic      rst_n,
  bldcsc_in_if.sink     in_chan,
  bldcsc_out_if.source  out_chan,
  bldcsc_cfg_if.sink    cfg_chan
);

  bldcsc_pkg::cfg_t      cfg_r;
  bldcsc_pkg::in_item_t  s1_item_r;
  logic                  s1_valid_r;
  bldcsc_pkg::out_item_t out_item_r;
  logic                  out_valid_r;
  bldcsc_pkg::out_item_t result;
  logic                  advance, fire, in_acc;

  assign advance        = !out_valid_r || out_chan.ready;
  assign fire           = s1_valid_r && advance;
  assign in_chan.ready  = !s1_valid_r || advance;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_max   <= bldcsc_pkg::PERIOD_MAX_RST;
      cfg_r.phase_angle  <= bldcsc_pkg::PHASE_ANGLE_RST;
      cfg_r.phase_offset <= bldcsc_pkg::PHASE_OFFS_RST;
      cfg_r.rising_mask  <= bldcsc_pkg::RISING_MASK_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        bldcsc_pkg::CFG_PERIOD_MAX:  cfg_r.period_max <= cfg_chan.data;
        bldcsc_pkg::CFG_PHASE_ANGLE: cfg_r.phase_angle <= cfg_chan.data[bldcsc_pkg::ANGLE_W-1:0];
        bldcsc_pkg::CFG_PHASE_OFFS:  cfg_r.phase_offset <= cfg_chan.data[bldcsc_pkg::OFFSET_W-1:0];
        bldcsc_pkg::CFG_RISING_MASK: cfg_r.rising_mask <= cfg_chan.data[bldcsc_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // input item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.kind         <= in_chan.kind;
      s1_item_r.comparator   <= in_chan.comparator;
      s1_item_r.first_period <= in_chan.first_period;
      s1_item_r.delay_min    <= in_chan.delay_min;
    end
  end

  bldcsc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.drive_index   = out_item_r.drive_index;
  assign out_chan.next_index    = out_item_r.next_index;
  assign out_chan.commutated    = out_item_r.commutated;
  assign out_chan.detect_done   = out_item_r.detect_done;
  assign out_chan.crossing_seen = out_item_r.crossing_seen;
  assign out_chan.step_total    = out_item_r.step_total;
  assign out_chan.period_out    = out_item_r.period_out;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> s1_valid_r && out_valid_r && !out_chan.ready)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

>>> verif/tb_bldc_sensorless_commutation_top.sv
// testbench for the sensorless bldc commutation block with a tick-accurate motor model
module tb_bldc_sensorless_commutation_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int PHASE_ITEMS     = 60;
  localparam logic [bldcsc_pkg::FIELD_W-1:0] TIMER_MAX = '1;

  typedef enum logic [1:0] {
    MOTOR_IDLE   = 2'd0,
    MOTOR_BLANK  = 2'd1,
    MOTOR_DETECT = 2'd2
  } motor_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  bldcsc_in_if  in_chan();
  bldcsc_out_if out_chan();
  bldcsc_cfg_if cfg_chan();

  bldc_sensorless_commutation_top #(
    .TIMER_BITS(bldcsc_pkg::FIELD_W)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #4 clk = ~clk;

  // motor model state and register copy
  bldcsc_pkg::cfg_t                    cfg_shadow;
  logic [bldcsc_pkg::FIELD_W-1:0]      stamp, since_comm, per, last_cross, comm_at, det_at;
  logic [bldcsc_pkg::LIMIT_W-1:0]      tmo_lim;
  motor_mode_t                         motor_mode;
  logic [bldcsc_pkg::COUNT_W-1:0]      cross_cnt;
  logic [bldcsc_pkg::STEP_W-1:0]       step_idx;
  logic [bldcsc_pkg::INDEX_W-1:0]      cur_drive, pend_drive;
  logic [bldcsc_pkg::OFFSET_W-1:0]     act_offs;

  bldcsc_pkg::in_item_t  cmd_backlog[$];
  bldcsc_pkg::out_item_t reports_due[$];

  int  err_count = 0;
  int  idle_cycles = 0;
  int  issued = 0;
  int  starts_taken = 0, ticks_taken = 0, settings_used = 0;
  int  crossings = 0, timeouts = 0, commutations = 0;
  bit  in_fire = 1'b0;
  bit  hold_off_req = 1'b0;
  int  hold_left = 0;
  int  burst_left = 1, gap_left = 0;
  logic [15:0] stall_bits = '1;
  logic [3:0]  stall_pos = '0;

  function automatic void close_window(logic seen);
    logic [bldcsc_pkg::FIELD_W-1:0]                     span;
    logic [bldcsc_pkg::FIELD_W:0]                       sum;
    logic [bldcsc_pkg::FIELD_W+bldcsc_pkg::ANGLE_W-1:0] lead;
    logic [bldcsc_pkg::FIELD_W+1:0]                     three_q;
    span = stamp - last_cross;
    last_cross = stamp;
    sum = {1'b0, per} + {1'b0, span};
    per = sum[bldcsc_pkg::FIELD_W:1];
    if (per > cfg_shadow.period_max) per = cfg_shadow.period_max;
    if (seen) cross_cnt = cross_cnt + 1'b1;
    lead = per * cfg_shadow.phase_angle;
    comm_at = lead[bldcsc_pkg::FIELD_W+bldcsc_pkg::ANGLE_W-1:bldcsc_pkg::ANGLE_W];
    since_comm = '0;
    three_q = per * 2'd3;
    det_at = stamp + three_q[bldcsc_pkg::FIELD_W+1:2];
    step_idx = (step_idx == bldcsc_pkg::STEP_LAST) ? '0 : step_idx + 1'b1;
    pend_drive = bldcsc_pkg::INDEX_W'(step_idx) + bldcsc_pkg::INDEX_W'(act_offs);
    motor_mode = MOTOR_BLANK;
  endfunction

  function automatic bldcsc_pkg::out_item_t step_motor(bldcsc_pkg::in_item_t cmd);
    bldcsc_pkg::out_item_t rep;
    logic                  want;
    rep = '0;
    if (cmd.kind) begin
      per = cmd.first_period;
      since_comm = '0;
      comm_at = cmd.first_period;
      last_cross = stamp;
      det_at = stamp + cmd.delay_min;
      cross_cnt = '0;
      cur_drive = bldcsc_pkg::INDEX_W'(step_idx);
      pend_drive = bldcsc_pkg::INDEX_W'(step_idx);
      act_offs = cfg_shadow.phase_offset;
      motor_mode = MOTOR_BLANK;
    end else begin
      stamp = stamp + 1'b1;
      since_comm = since_comm + 1'b1;
      if (comm_at != TIMER_MAX && since_comm >= comm_at) begin
        cur_drive = pend_drive;
        comm_at = TIMER_MAX;
        rep.commutated = 1'b1;
      end
      if (motor_mode == MOTOR_BLANK && stamp == det_at) begin
        since_comm = '0;
        comm_at = TIMER_MAX;
        tmo_lim = {per, 1'b0};
        motor_mode = MOTOR_DETECT;
      end
      if (motor_mode == MOTOR_DETECT) begin
        want = cfg_shadow.rising_mask[step_idx];
        if (cmd.comparator == want) begin
          rep.detect_done = 1'b1;
          rep.crossing_seen = 1'b1;
          close_window(1'b1);
        end else if (bldcsc_pkg::LIMIT_W'(since_comm) >= tmo_lim) begin
          rep.detect_done = 1'b1;
          close_window(1'b0);
        end
      end
    end
    rep.drive_index = cur_drive;
    rep.next_index = pend_drive;
    rep.step_total = cross_cnt;
    rep.period_out = per;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  task automatic push_start(logic [bldcsc_pkg::FIELD_W-1:0] first_period,
                            logic [bldcsc_pkg::FIELD_W-1:0] delay_min);
    bldcsc_pkg::in_item_t cmd;
    cmd.kind = 1'b1;
    cmd.comparator = 1'($urandom_range(0, 1));
    cmd.first_period = first_period;
    cmd.delay_min = delay_min;
    cmd_backlog.push_back(cmd);
    issued++;
  endtask

  task automatic push_tick(logic level);
    bldcsc_pkg::in_item_t cmd;
    cmd.kind = 1'b0;
    cmd.comparator = level;
    cmd.first_period = bldcsc_pkg::FIELD_W'($urandom);
    cmd.delay_min = bldcsc_pkg::FIELD_W'($urandom);
    cmd_backlog.push_back(cmd);
    issued++;
  endtask

  task automatic write_reg(bldcsc_pkg::cfg_idx_t idx, logic [bldcsc_pkg::FIELD_W-1:0] val);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    unique case (idx)
      bldcsc_pkg::CFG_PERIOD_MAX:  cfg_shadow.period_max = val;
      bldcsc_pkg::CFG_PHASE_ANGLE: cfg_shadow.phase_angle = val[bldcsc_pkg::ANGLE_W-1:0];
      bldcsc_pkg::CFG_PHASE_OFFS:  cfg_shadow.phase_offset = val[bldcsc_pkg::OFFSET_W-1:0];
      bldcsc_pkg::CFG_RISING_MASK: cfg_shadow.rising_mask = val[bldcsc_pkg::MASK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic program_motor(logic [bldcsc_pkg::FIELD_W-1:0] pmax,
                               logic [bldcsc_pkg::ANGLE_W-1:0] angle,
                               logic [bldcsc_pkg::OFFSET_W-1:0] offs,
                               logic [bldcsc_pkg::MASK_W-1:0] mask);
    write_reg(bldcsc_pkg::CFG_PERIOD_MAX, pmax);
    write_reg(bldcsc_pkg::CFG_PHASE_ANGLE, bldcsc_pkg::FIELD_W'(angle));
    write_reg(bldcsc_pkg::CFG_PHASE_OFFS, bldcsc_pkg::FIELD_W'(offs));
    write_reg(bldcsc_pkg::CFG_RISING_MASK, bldcsc_pkg::FIELD_W'(mask));
    settings_used++;
    @(posedge clk);
  endtask

  task automatic drain_motor();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || in_chan.valid || reports_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // item driver
  always @(negedge clk) begin : drive_cmds
    bldcsc_pkg::in_item_t cmd;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        cmd = cmd_backlog.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.kind <= cmd.kind;
        in_chan.comparator <= cmd.comparator;
        in_chan.first_period <= cmd.first_period;
        in_chan.delay_min <= cmd.delay_min;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_chan.ready <= 1'b0;
    end else begin
      if (stall_pos == 0)
        stall_bits = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      out_chan.ready <= stall_bits[stall_pos];
      stall_pos = stall_pos + 1'b1;
    end
  end

  // handshake monitor, checker and watchdog
  always @(posedge clk) begin : watch_motor
    bldcsc_pkg::in_item_t  cmd;
    bldcsc_pkg::out_item_t want;
    bit                    busy;
    in_fire = 1'b0;
    if (rst_n) begin
      busy = 1'b0;
      if (out_chan.valid && out_chan.ready) begin
        busy = 1'b1;
        if (reports_due.size() == 0) begin
          $error("result item with nothing expected");
          err_count++;
        end else begin
          want = reports_due.pop_front();
          check_field("drive_index", want.drive_index, out_chan.drive_index);
          check_field("next_index", want.next_index, out_chan.next_index);
          check_field("commutated", want.commutated, out_chan.commutated);
          check_field("detect_done", want.detect_done, out_chan.detect_done);
          check_field("crossing_seen", want.crossing_seen, out_chan.crossing_seen);
          check_field("step_total", want.step_total, out_chan.step_total);
          check_field("period_out", want.period_out, out_chan.period_out);
          crossings += want.crossing_seen;
          timeouts += (want.detect_done && !want.crossing_seen);
          commutations += want.commutated;
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        busy = 1'b1;
        in_fire = 1'b1;
        cmd.kind = in_chan.kind;
        cmd.comparator = in_chan.comparator;
        cmd.first_period = in_chan.first_period;
        cmd.delay_min = in_chan.delay_min;
        reports_due.push_back(step_motor(cmd));
        if (cmd.kind) starts_taken++;
        else ticks_taken++;
      end
      if (cfg_chan.valid && cfg_chan.ready) busy = 1'b1;
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_bldc_sensorless_commutation_top: errors");
        $finish;
      end
    end
  end

  initial begin
    int  pick, ticks, style, cmp_run;
    logic lvl;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.kind = 1'b0;
    in_chan.comparator = 1'b0;
    in_chan.first_period = '0;
    in_chan.delay_min = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = bldcsc_pkg::CFG_PERIOD_MAX;
    cfg_chan.data = '0;
    cfg_shadow = '{bldcsc_pkg::PERIOD_MAX_RST, bldcsc_pkg::PHASE_ANGLE_RST,
                   bldcsc_pkg::PHASE_OFFS_RST, bldcsc_pkg::RISING_MASK_RST};
    stamp = '0;
    since_comm = '0;
    per = '0;
    last_cross = '0;
    comm_at = TIMER_MAX;
    det_at = '0;
    tmo_lim = '0;
    motor_mode = MOTOR_IDLE;
    cross_cnt = '0;
    step_idx = '0;
    cur_drive = '0;
    pend_drive = '0;
    act_offs = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle ticks, zero period with instant timeout, full-scale start, short windows
    push_tick(1'b0);
    push_tick(1'b1);
    push_start(24'd0, 24'd1);
    push_tick(1'b0);
    push_tick(1'b1);
    push_start(24'd4, 24'd2);
    repeat (4) push_tick(1'b1);
    push_start(24'hFFFFFF, 24'hFFFFFF);
    push_tick(1'b1);
    push_tick(1'b0);
    push_start(24'd6, 24'd1);
    repeat (5) begin
      push_tick(1'b1);
      push_tick(1'b0);
    end
    drain_motor();

    for (int ph = 0; ph < 5; ph++) begin
      unique case (ph)
        0: program_motor(24'hFFFFFF, 6'd63, 4'd12, 6'h3F);
        1: program_motor(24'd0, 6'd0, 4'd0, 6'h00);
        2: program_motor(24'd8, 6'd32, 4'd6, 6'h2A);
        3: program_motor(24'($urandom_range(1, 40)), 6'($urandom), 4'd15, 6'($urandom));
        default: program_motor(bldcsc_pkg::PERIOD_MAX_RST, bldcsc_pkg::PHASE_ANGLE_RST,
                               bldcsc_pkg::PHASE_OFFS_RST, bldcsc_pkg::RISING_MASK_RST);
      endcase
      issued = 0;
      while (issued < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        style = 0;
        if (pick < 75) begin
          push_start(24'($urandom_range(0, 30)), 24'($urandom_range(0, 12)));
          ticks = $urandom_range(10, 60);
          style = $urandom_range(0, 2);
        end else if (pick < 85) begin
          ticks = $urandom_range(1, 15);
        end else if (pick < 92) begin
          push_start(24'($urandom), 24'($urandom));
          ticks = $urandom_range(5, 20);
        end else begin
          push_start(24'($urandom_range(0, 30)), 24'($urandom_range(0, 12)));
          push_start(24'($urandom_range(0, 30)), 24'($urandom_range(0, 12)));
          ticks = $urandom_range(2, 8);
        end
        cmp_run = 0;
        lvl = 1'b0;
        repeat (ticks) begin
          if (style == 0) begin
            lvl = 1'($urandom_range(0, 1));
          end else if (cmp_run == 0) begin
            lvl = 1'($urandom_range(0, 1));
            cmp_run = (style == 1) ? $urandom_range(1, 40) : 1000;
          end else begin
            cmp_run--;
          end
          push_tick(lvl);
        end
      end
      if (ph == 2) hold_off_req = 1'b1;
      drain_motor();
    end

    $display("run covered %0d starts and %0d ticks under %0d register settings",
             starts_taken, ticks_taken, settings_used + 1);
    $display("windows closed on %0d crossings and %0d timeouts, %0d commutations",
             crossings, timeouts, commutations);
    if (err_count == 0) begin
      $display("tb_bldc_sensorless_commutation_top: clean");
    end else begin
      $display("tb_bldc_sensorless_commutation_top: errors");
    end
    $finish;
  end

endmodule
